// File: hdl/wsdfr_pkg.sv
package wsdfr_pkg;

	localparam int LEN_BITS = 64;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = 2;

	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] IND_LEN16 = 7'd126;
	localparam logic [6:0] IND_LEN64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	typedef enum logic [2:0] {
		ACT_BINARY = 3'd0,
		ACT_CLOSE  = 3'd1,
		ACT_PING   = 3'd2,
		ACT_PONG   = 3'd3,
		ACT_OTHER  = 3'd4
	} action_t;

	// One classified byte on its way to the output stage.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       has_data;
		logic [3:0] opcode;
		logic       frame_end;
		action_t    action;
		logic       pos0;
		logic       pos1;
		logic       code_ok;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

	function automatic action_t action_of(input logic [3:0] op);
		action_t a;
		case (op)
			OP_BINARY: a = ACT_BINARY;
			OP_CLOSE:  a = ACT_CLOSE;
			OP_PING:   a = ACT_PING;
			OP_PONG:   a = ACT_PONG;
			default:   a = ACT_OTHER;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/wsdfr_if.sv
interface wsdfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdfr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        has_data;
	logic [3:0]  frame_opcode;
	logic        frame_end;
	logic [2:0]  frame_action;
	logic [15:0] close_code;
	logic        halted;

	modport source (
		output valid, output data_byte, output has_data, output frame_opcode,
		output frame_end, output frame_action, output close_code, output halted,
		input ready
	);
	modport sink (
		input valid, input data_byte, input has_data, input frame_opcode,
		input frame_end, input frame_action, input close_code, input halted,
		output ready
	);
endinterface

// File: hdl/wsdfr_front.sv
module wsdfr_front (
	input  logic              clk,
	input  logic              arst_n,
	wsdfr_in_if.sink          in_ch,
	input  logic              q_full,
	output wsdfr_pkg::q_push_t push
);
	import wsdfr_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_EXT,
		PH_MASK,
		PH_PAY
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [3:0]          op_q, op_n;
	logic                mask_q, mask_n;
	logic [LEN_BITS-1:0] len_q, len_n;
	logic [LEN_BITS-1:0] rem_q, rem_n;
	logic [3:0]          ext_q, ext_n;
	logic [31:0]         key_q, key_n;
	logic [1:0]          mcnt_q, mcnt_n;
	logic [1:0]          k_q, k_n;
	logic [1:0]          seen_q, seen_n;
	logic                stop_q, stop_n;

	logic       acc;
	logic [7:0] b;
	logic       go_len, go_hdr, fin;

	assign in_ch.ready = stop_q | ~q_full;
	assign acc         = in_ch.valid & in_ch.ready;
	assign b           = in_ch.rx_byte;

	always_comb begin
		phase_n = phase_q;
		op_n    = op_q;
		mask_n  = mask_q;
		len_n   = len_q;
		rem_n   = rem_q;
		ext_n   = ext_q;
		key_n   = key_q;
		mcnt_n  = mcnt_q;
		k_n     = k_q;
		seen_n  = seen_q;
		stop_n  = stop_q;
		go_len  = 1'b0;
		go_hdr  = 1'b0;
		fin     = 1'b0;
		push    = '0;
		if (acc && !stop_q) begin
			case (phase_q)
				PH_HDR1: begin
					op_n    = b[3:0];
					key_n   = '0;
					phase_n = PH_HDR2;
				end
				PH_HDR2: begin
					mask_n = b[7];
					len_n  = '0;
					if (b[6:0] == IND_LEN16) begin
						ext_n   = EXT16_BYTES;
						phase_n = PH_EXT;
					end else if (b[6:0] == IND_LEN64) begin
						ext_n   = EXT64_BYTES;
						phase_n = PH_EXT;
					end else begin
						len_n  = LEN_BITS'(b[6:0]);
						go_len = 1'b1;
					end
				end
				PH_EXT: begin
					len_n = {len_q[LEN_BITS-9:0], b};
					ext_n = ext_q - 4'd1;
					if (ext_q == 4'd1) begin
						go_len = 1'b1;
					end
				end
				PH_MASK: begin
					key_n  = {key_q[23:0], b};
					mcnt_n = mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						go_hdr = 1'b1;
					end
				end
				PH_PAY: begin
					push.valid           = 1'b1;
					push.entry.data      = b;
					push.entry.key       = mask_q ? key_q[{~k_q, 3'b000} +: 8] : 8'h00;
					push.entry.has_data  = 1'b1;
					push.entry.opcode    = op_q;
					push.entry.pos0      = (seen_q == 2'd0);
					push.entry.pos1      = (seen_q == 2'd1);
					push.entry.code_ok   = (seen_q != 2'd0);
					push.entry.frame_end = (rem_q == LEN_BITS'(1));
					push.entry.action    = ACT_BINARY;
					rem_n = rem_q - LEN_BITS'(1);
					k_n   = k_q + 2'd1;
					if (seen_q != 2'd2) begin
						seen_n = seen_q + 2'd1;
					end
					if (rem_q == LEN_BITS'(1)) begin
						push.entry.action = action_of(op_q);
						fin = 1'b1;
					end
				end
				default: begin
					phase_n = PH_HDR1;
				end
			endcase

			if (go_len) begin
				if (mask_n) begin
					mcnt_n  = 2'd0;
					phase_n = PH_MASK;
				end else begin
					go_hdr = 1'b1;
				end
			end

			if (go_hdr) begin
				if (len_n == '0) begin
					// empty frame: end result straight from the header
					push.valid           = 1'b1;
					push.entry           = '0;
					push.entry.opcode    = op_q;
					push.entry.frame_end = 1'b1;
					push.entry.action    = action_of(op_q);
					fin = 1'b1;
				end else begin
					rem_n   = len_n;
					k_n     = 2'd0;
					seen_n  = 2'd0;
					phase_n = PH_PAY;
				end
			end

			if (fin) begin
				phase_n = PH_HDR1;
				if (action_of(op_q) == ACT_CLOSE) begin
					stop_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			op_q    <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			rem_q   <= '0;
			ext_q   <= '0;
			key_q   <= '0;
			mcnt_q  <= '0;
			k_q     <= '0;
			seen_q  <= '0;
			stop_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			op_q    <= op_n;
			mask_q  <= mask_n;
			len_q   <= len_n;
			rem_q   <= rem_n;
			ext_q   <= ext_n;
			key_q   <= key_n;
			mcnt_q  <= mcnt_n;
			k_q     <= k_n;
			seen_q  <= seen_n;
			stop_q  <= stop_n;
		end
	end

endmodule

// File: hdl/wsdfr_queue.sv
module wsdfr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  wsdfr_pkg::q_push_t push,
	output logic               full,
	output wsdfr_pkg::q_head_t head,
	input  logic               pop
);
	import wsdfr_pkg::*;

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push, do_pop;

	assign full       = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_q];
	assign do_push    = push.valid & ~full;
	assign do_pop     = pop & head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/wsdfr_back.sv
module wsdfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wsdfr_pkg::q_head_t head,
	output logic               pop,
	wsdfr_out_if.source        out_ch
);
	import wsdfr_pkg::*;

	logic        ov_q;
	logic [7:0]  data_q;
	logic        has_q;
	logic [3:0]  op_q;
	logic        end_q;
	logic [2:0]  act_q;
	logic [15:0] code_q;
	logic        halt_q;
	logic [15:0] cap_q;

	logic [7:0]  d;
	logic [15:0] cap_n;
	logic        is_close;

	assign pop      = head.valid & (~ov_q | out_ch.ready);
	assign d        = head.entry.data ^ head.entry.key;
	assign is_close = head.entry.frame_end & (head.entry.action == ACT_CLOSE);

	always_comb begin
		cap_n = cap_q;
		if (head.entry.pos0) begin
			cap_n = {d, 8'h00};
		end else if (head.entry.pos1) begin
			cap_n = {cap_q[15:8], d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			cap_q <= '0;
		end else begin
			if (pop) begin
				ov_q  <= 1'b1;
				cap_q <= cap_n;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= d;
			has_q  <= head.entry.has_data;
			op_q   <= head.entry.opcode;
			end_q  <= head.entry.frame_end;
			act_q  <= head.entry.action;
			code_q <= (is_close && head.entry.code_ok) ? cap_n : 16'h0000;
			halt_q <= is_close;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.data_byte    = data_q;
	assign out_ch.has_data     = has_q;
	assign out_ch.frame_opcode = op_q;
	assign out_ch.frame_end    = end_q;
	assign out_ch.frame_action = act_q;
	assign out_ch.close_code   = code_q;
	assign out_ch.halted       = halt_q;

endmodule

// File: hdl/websocket_frame_deframer.sv
// Data path: an accepted byte is written into the queue at the edge that accepts it,
// and the output register takes the queue head once it is empty or being drained.
// Throughput: one byte per cycle while the four-entry queue has room and the
// consumer holds ready high; the output register drains one entry per cycle.
// Reset: arst_n clears parser state and stop flag, queue pointers and output valid.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	wsdfr_in_if.sink    in_ch,
	wsdfr_out_if.source out_ch
);
	import wsdfr_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;

	wsdfr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push)
	);

	wsdfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	wsdfr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
